// ===== sv/planar_odometry_integrator_assert.svh =====
`ifndef PLANAR_ODOMETRY_INTEGRATOR_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define POI_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define POI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/poi_pkg.sv =====
package poi_pkg;

    localparam logic [30:0]        INV_PI_Q32      = 31'd1367130551;
    localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
    localparam logic signed [33:0] UNIT_Q30        = 34'sd1073741824;
    localparam logic [19:0]        STEP_RESET      = 20'd16777;

    localparam logic [1:0] REG_METHOD = 2'd0;
    localparam logic [1:0] REG_STEP   = 2'd1;

    localparam logic CMD_POSE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_SUM,
        ST_HEAD,
        ST_CSTART,
        ST_CWAIT,
        ST_MUL_Y,
        ST_ADD_X,
        ST_ADD_Y,
        ST_QSTART,
        ST_QWAIT
    } t_state;

    typedef struct packed {
        logic               done;
        logic signed [31:0] cos_q;
        logic signed [31:0] sin_q;
    } t_cordic_res;

    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0029;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            5'd28:   v = 32'h0000_0003;
            5'd29:   v = 32'h0000_0001;
            5'd30:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > UNIT_Q30) begin
            r = 32'(UNIT_Q30);
        end else if (v < -UNIT_Q30) begin
            r = 32'(-UNIT_Q30);
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [23:0] b);
        logic signed [32:0] s;
        logic signed [31:0] r;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) begin
            r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/planar_odometry_integrator.sv =====
// Dead-reckoning pose integrator. Each word on the input stream is a velocity sample or, when
// tuser is set, a set-pose command; each gives exactly one result word with the pose, the
// yaw quaternion and the velocities of the item. One multiplier and one CORDIC rotator are
// shared under a sequencer, so the input is ready again only once the last item's result
// has gone into the output register. A velocity sample takes two CORDIC runs, one for the
// motion direction and one for the half-heading quaternion; a set pose takes only the latter
// run. A finished result waits in the output register while the next word is taken.
// Configuration writes are accepted in every cycle and must only be issued while idle.
module planar_odometry_integrator import poi_pkg::*; #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // lin_vel[23:0], ang_vel[47:24], pose_x[79:48], pose_y[111:80], pose_heading[143:112]
    input  logic [143:0] i_s_tdata,
    // cmd[0]
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // pos_x[31:0], pos_y[63:32], heading[95:64], quat_z[127:96], quat_w[159:128],
    // vel_echo[183:160], rate_echo[207:184]
    output logic [207:0] o_m_tdata,
    // method_used[0]
    output logic         o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_addr,
    input  logic [19:0]  i_cfg_data
);

    t_state              r_state;
    t_state              n_state;

    logic                r_method;
    logic [19:0]         r_step;

    logic signed [31:0]  r_x_acc;
    logic signed [31:0]  r_y_acc;
    logic [31:0]         r_head;

    logic                r_meth;
    logic signed [23:0]  r_lin;
    logic signed [23:0]  r_ang;
    logic                r_neg;
    logic [43:0]         r_mag;
    logic signed [31:0]  r_d;
    logic [52:0]         r_hk;
    logic [53:0]         r_sum;
    logic [31:0]         r_off;
    logic signed [23:0]  r_dx;
    logic signed [23:0]  r_dy;

    logic                r_m_tvalid;
    logic [207:0]        r_m_tdata;
    logic                r_m_tuser;

    logic signed [32:0]  w_mul_a;
    logic signed [32:0]  w_mul_b;
    logic signed [65:0]  w_prod;
    logic                w_cstart;
    logic [31:0]         w_cangle;
    t_cordic_res         w_cres;

    logic                w_in_acc;
    logic                w_load;
    logic signed [43:0]  w_p;
    logic signed [43:0]  w_dsum;
    logic signed [65:0]  w_rnd;
    logic [53:0]         w_dth_sum;
    logic [53:0]         w_off_sum;
    logic [31:0]         w_dth;
    logic [31:0]         w_off;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_load      = (r_state == ST_QWAIT) && w_cres.done && (!r_m_tvalid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= 1'b0;
            r_step   <= STEP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_METHOD: r_method <= i_cfg_data[0];
                REG_STEP:   r_step   <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        w_mul_a  = 33'(r_d);
        w_mul_b  = 33'(w_cres.cos_q);
        w_cstart = 1'b0;
        w_cangle = r_head + (r_meth ? r_off : 32'd0);
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_s_tuser == CMD_POSE) ? ST_QSTART : ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                w_mul_a = 33'(r_ang);
                w_mul_b = signed'({13'd0, r_step});
                n_state = ST_MUL_D;
            end
            ST_MUL_D: begin
                w_mul_a = 33'(r_lin);
                w_mul_b = signed'({13'd0, r_step});
                n_state = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                w_mul_a = signed'({11'd0, r_mag[43:22]});
                w_mul_b = signed'({2'd0, INV_PI_Q32});
                n_state = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                w_mul_a = signed'({11'd0, r_mag[21:0]});
                w_mul_b = signed'({2'd0, INV_PI_Q32});
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = ST_HEAD;
            end
            ST_HEAD: begin
                n_state = ST_CSTART;
            end
            ST_CSTART: begin
                w_cstart = 1'b1;
                n_state  = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (w_cres.done) begin
                    n_state = ST_MUL_Y;
                end
            end
            ST_MUL_Y: begin
                w_mul_b = 33'(w_cres.sin_q);
                n_state = ST_ADD_X;
            end
            ST_ADD_X: begin
                n_state = ST_ADD_Y;
            end
            ST_ADD_Y: begin
                n_state = ST_QSTART;
            end
            ST_QSTART: begin
                w_cstart = 1'b1;
                w_cangle = {r_head[31], r_head[31:1]};
                n_state  = ST_QWAIT;
            end
            ST_QWAIT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_p       = w_prod[43:0];
    assign w_dsum    = w_p + 44'sd2048;
    assign w_rnd     = w_prod + 66'sh200_0000_0000;
    assign w_dth_sum = r_sum + 54'h4_0000;
    assign w_off_sum = r_sum + 54'h8_0000;
    assign w_dth     = w_dth_sum[50:19];
    assign w_off     = w_off_sum[51:20];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_acc <= '0;
            r_y_acc <= '0;
            r_head  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_meth <= r_method;
                        if (i_s_tuser == CMD_POSE) begin
                            r_lin   <= '0;
                            r_ang   <= '0;
                            r_x_acc <= i_s_tdata[79:48];
                            r_y_acc <= i_s_tdata[111:80];
                            r_head  <= i_s_tdata[143:112];
                        end else begin
                            r_lin <= i_s_tdata[23:0];
                            r_ang <= i_s_tdata[47:24];
                        end
                    end
                end
                ST_MUL_D: begin
                    r_neg <= w_p[43];
                    r_mag <= w_p[43] ? 44'(-w_p) : 44'(w_p);
                end
                ST_MUL_HI: begin
                    r_d <= w_dsum[43:12];
                end
                ST_MUL_LO: begin
                    r_hk <= w_prod[52:0];
                end
                ST_SUM: begin
                    r_sum <= {1'b0, r_hk} + 54'(w_prod[52:22]);
                end
                ST_HEAD: begin
                    r_head <= r_neg ? (r_head - w_dth) : (r_head + w_dth);
                    r_off  <= r_neg ? (32'd0 - w_off) : w_off;
                end
                ST_MUL_Y: begin
                    r_dx <= w_rnd[65:42];
                end
                ST_ADD_X: begin
                    r_dy    <= w_rnd[65:42];
                    r_x_acc <= sat_add(r_x_acc, r_dx);
                end
                ST_ADD_Y: begin
                    r_y_acc <= sat_add(r_y_acc, r_dy);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_tdata <= {r_ang, r_lin, w_cres.cos_q, w_cres.sin_q, r_head, r_y_acc, r_x_acc};
            r_m_tuser <= r_meth;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    poi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    poi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_angle (w_cangle),
        .o_res   (w_cres)
    );

endmodule

// ===== sv/poi_mul.sv =====
module poi_mul import poi_pkg::*; (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);

    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 66'(i_a) * 66'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== sv/poi_cordic.sv =====
module poi_cordic import poi_pkg::*; #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_angle,
    output t_cordic_res o_res
);

    localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

    logic                r_busy;
    logic                r_done;
    logic                r_flip;
    logic [CNT_W-1:0]    r_cnt;
    logic signed [33:0]  r_x;
    logic signed [33:0]  r_y;
    logic signed [33:0]  r_z;
    logic signed [31:0]  r_cos;
    logic signed [31:0]  r_sin;

    logic [4:0]          w_idx;
    logic signed [33:0]  w_xs;
    logic signed [33:0]  w_ys;
    logic signed [33:0]  w_atan;
    logic [31:0]         w_shift;
    logic                w_fold;
    logic [31:0]         w_zin;
    logic                w_last;

    assign w_idx   = 5'(r_cnt);
    assign w_xs    = r_x >>> w_idx;
    assign w_ys    = r_y >>> w_idx;
    assign w_atan  = signed'({2'b00, atan_bam(w_idx)});
    assign w_shift = i_angle - 32'h4000_0000;
    assign w_fold  = !w_shift[31];
    assign w_zin   = w_fold ? (i_angle ^ 32'h8000_0000) : i_angle;
    assign w_last  = (r_cnt == CNT_W'(CORDIC_STEPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_flip <= w_fold;
            r_x    <= CORDIC_INV_GAIN;
            r_y    <= '0;
            r_z    <= 34'(signed'(w_zin));
        end else if (r_busy) begin
            if (w_last) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
                r_cos  <= clamp_unit(r_flip ? -r_x : r_x);
                r_sin  <= clamp_unit(r_flip ? -r_y : r_y);
            end else begin
                r_cnt <= r_cnt + 1'b1;
                if (!r_z[33]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_atan;
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.cos_q = r_cos;
    assign o_res.sin_q = r_sin;

endmodule

// ===== sv/poi_chk.sv =====
`include "planar_odometry_integrator_assert.svh"

module poi_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [207:0] o_m_tdata
);

    `POI_ASSERT_CLK(a_busy_after_accept, i_s_tvalid && o_s_tready |=> !o_s_tready, "input ready right after a word was taken")
    `POI_ASSERT_CLK(a_result_from_work, $rose(o_m_tvalid) |-> $past(!o_s_tready), "result appeared while the block was idle")
    `POI_ASSERT_ALWAYS(a_reset_state, !i_rst_n |=> !o_m_tvalid && o_s_tready, "block not idle after reset")
    `POI_ASSERT_CLK(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "stalled result word changed")

endmodule

bind planar_odometry_integrator poi_chk u_poi_chk (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import poi_pkg::*;

    localparam logic       CMD_MOTION = 1'b0;
    localparam logic [1:0] REG_SPARE_A = 2'd2;
    localparam logic [1:0] REG_SPARE_B = 2'd3;
    localparam int         ROTATE_STEPS = 24;
    localparam int         SETTLE_CYCLES = 80;
    localparam int         PHASE_WORDS = 205;

    localparam logic [31:0] BAM_ATAN [0:23] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
        32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] heading;
        logic [31:0] qz;
        logic [31:0] qw;
        logic [23:0] vel;
        logic [23:0] rate;
        logic        method;
    } t_pose;

    class pose_tracker;
        logic        method;
        logic [19:0] step;
        longint      x_pos;
        longint      y_pos;
        logic [31:0] yaw;
        t_pose       expected_poses[$];
        int          mismatches;

        function new();
            method = 1'b0;
            step = STEP_RESET;
            x_pos = 0;
            y_pos = 0;
            yaw = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_poses.size();
        endfunction

        function void write_reg(logic [1:0] addr, logic [19:0] data);
            if (addr == REG_METHOD) begin
                method = data[0];
            end else if (addr == REG_STEP) begin
                step = data;
            end
        endfunction

        // Turns ang_vel * step into a binary angle: times 2^32/pi, over 2^shift, rounded
        // half away from zero.
        function logic [31:0] angle_step(longint p, int shift);
            longint unsigned mag;
            longint unsigned hi;
            longint unsigned lo;
            longint unsigned r;
            mag = (p < 0) ? longint'(0) - p : p;
            hi = mag >> 22;
            lo = mag & 64'h3F_FFFF;
            r = (hi * 64'(INV_PI_Q32) + ((lo * 64'(INV_PI_Q32)) >> 22)
                 + (64'd1 << (shift - 23))) >> (shift - 22);
            return (p < 0) ? 32'd0 - r[31:0] : r[31:0];
        endfunction

        function longint limit_unit(longint v);
            if (v > longint'(UNIT_Q30)) begin
                return longint'(UNIT_Q30);
            end
            if (v < -longint'(UNIT_Q30)) begin
                return -longint'(UNIT_Q30);
            end
            return v;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        function void rotate(logic [31:0] angle, output longint c, output longint s);
            logic        flip;
            logic [31:0] a;
            logic [31:0] off;
            longint      cx;
            longint      cy;
            longint      z;
            longint      xs;
            longint      ys;
            a = angle;
            off = a - 32'h4000_0000;
            flip = 1'b0;
            if (off < 32'h8000_0000) begin
                a = a - 32'h8000_0000;
                flip = 1'b1;
            end
            z = longint'(signed'(a));
            cx = longint'(CORDIC_INV_GAIN);
            cy = 0;
            for (int i = 0; i < ROTATE_STEPS; i++) begin
                xs = cx >>> i;
                ys = cy >>> i;
                if (z >= 0) begin
                    cx = cx - ys;
                    cy = cy + xs;
                    z = z - longint'(BAM_ATAN[i]);
                end else begin
                    cx = cx + ys;
                    cy = cy - xs;
                    z = z + longint'(BAM_ATAN[i]);
                end
            end
            if (flip) begin
                cx = -cx;
                cy = -cy;
            end
            c = limit_unit(cx);
            s = limit_unit(cy);
        endfunction

        function void take_sample(logic cmd, logic [143:0] data);
            logic signed [23:0] lin;
            logic signed [23:0] ang;
            longint             p;
            longint             d;
            longint             c;
            longint             s;
            longint             qz;
            longint             qw;
            logic [31:0]        a;
            t_pose              e;
            lin = data[23:0];
            ang = data[47:24];
            if (cmd == CMD_POSE) begin
                x_pos = longint'(signed'(data[79:48]));
                y_pos = longint'(signed'(data[111:80]));
                yaw = data[143:112];
                lin = '0;
                ang = '0;
            end else begin
                p = longint'(ang) * longint'(step);
                d = (longint'(lin) * longint'(step) + 2048) >>> 12;
                yaw = yaw + angle_step(p, 41);
                a = yaw;
                if (method) begin
                    a = a + angle_step(p, 42);
                end
                rotate(a, c, s);
                x_pos = sat32(x_pos + ((d * c + (longint'(1) << 41)) >>> 42));
                y_pos = sat32(y_pos + ((d * s + (longint'(1) << 41)) >>> 42));
            end
            rotate({yaw[31], yaw[31:1]}, qw, qz);
            e.x = x_pos[31:0];
            e.y = y_pos[31:0];
            e.heading = yaw;
            e.qz = qz[31:0];
            e.qw = qw[31:0];
            e.vel = lin;
            e.rate = ang;
            e.method = method;
            expected_poses.push_back(e);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch on %s: expected %h, got %h.", field, want, got);
                end
            end
        endfunction

        function void check_pose(logic [207:0] data, logic user);
            t_pose e;
            if (expected_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result word %h arrived with nothing expected.", data);
                end
                return;
            end
            e = expected_poses.pop_front();
            compare("pos_x", e.x, data[31:0]);
            compare("pos_y", e.y, data[63:32]);
            compare("heading", e.heading, data[95:64]);
            compare("quat_z", e.qz, data[127:96]);
            compare("quat_w", e.qw, data[159:128]);
            compare("vel_echo", {8'd0, e.vel}, {8'd0, data[183:160]});
            compare("rate_echo", {8'd0, e.rate}, {8'd0, data[207:184]});
            compare("method_used", {31'd0, e.method}, {31'd0, user});
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [207:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_addr = '0;
    logic [19:0]  cfg_data = '0;

    int src_idle = 0;
    int sink_idle = 0;
    int sink_hold = 0;

    pose_tracker tracker = new();

    planar_odometry_integrator u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever begin
            #2 clk = ~clk;
        end
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side: checks every accepted word, then picks tready for the next edge.
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                tracker.check_pose(m_tdata, m_tuser);
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_idle);
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [143:0] data);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= data;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        tracker.take_sample(cmd, data);
    endtask

    task automatic drive_motion(input logic [23:0] lin, input logic [23:0] ang);
        send_word(CMD_MOTION, {$urandom(), $urandom(), $urandom(), ang, lin});
    endtask

    task automatic drive_pose(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] h);
        logic [31:0] junk;
        junk = $urandom();
        send_word(CMD_POSE, {h, y, x, junk[31:8], junk[23:0]});
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [19:0] data);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        tracker.write_reg(addr, data);
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [23:0] pick_rate();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(7))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'h00_0000;
            3, 4: return {{9{r[16]}}, r[14:0]};
            default: return r[23:0];
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [19:0] step;
        logic        cmd;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drive_motion(24'h00_0000, 24'h00_0000);
        drive_motion(24'h7F_FFFF, 24'h00_0000);
        drive_motion(24'h80_0000, 24'h00_0000);
        drive_motion(24'h00_0000, 24'h7F_FFFF);
        drive_motion(24'h00_0000, 24'h80_0000);
        drive_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
        drive_motion(24'h7F_FFFF, 24'h00_0000);
        drive_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        drive_motion(24'h7F_FFFF, 24'h00_0000);
        drive_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        drive_motion(24'h7F_FFFF, 24'h7F_FFFF);
        drive_pose(32'h0000_0000, 32'h0000_0000, 32'h4000_0000);
        drive_motion(24'h7F_FFFF, 24'h80_0000);
        drive_pose(32'h0000_0000, 32'h0000_0000, 32'hBFFF_FFFF);
        drive_motion(24'h80_0000, 24'h7F_FFFF);
        drive_pose(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        drain();

        write_reg(REG_METHOD, 20'h0_0001);
        write_reg(REG_STEP, 20'hF_FFFF);
        drive_motion(24'h7F_FFFF, 24'h7F_FFFF);
        drive_motion(24'h80_0000, 24'h80_0000);
        drive_motion(24'h7F_FFFF, 24'h80_0000);
        drain();

        write_reg(REG_STEP, 20'h0_0000);
        drive_motion(24'h7F_FFFF, 24'h7F_FFFF);
        drain();

        write_reg(REG_SPARE_A, 20'hF_FFFF);
        write_reg(REG_SPARE_B, 20'h5_5555);
        write_reg(REG_METHOD, 20'hF_FFFE);
        drive_motion(24'h12_3456, 24'hFE_DCBA);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: step = STEP_RESET;
                1: step = 20'hF_FFFF;
                2: step = 20'h0_0001;
                3: step = 20'hF_FFFF;
                4: step = 20'h0_0000;
                5: step = 20'($urandom());
                6: step = STEP_RESET;
                7: step = 20'($urandom());
                default: step = 20'hF_FFFF;
            endcase
            write_reg(REG_STEP, step);
            write_reg(REG_METHOD, {19'($urandom()), ph[0]});
            if (ph < 3) begin
                src_idle = 6;
                sink_idle = 68;
            end else if (ph < 6) begin
                src_idle = 68;
                sink_idle = 6;
            end else begin
                src_idle = 0;
                sink_idle = 0;
            end
            if (ph == 6) begin
                sink_hold = 2500;
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                cmd = ($urandom_range(99) < 8) ? CMD_POSE : CMD_MOTION;
                send_word(cmd, {pick_word(), pick_word(), pick_word(), pick_rate(),
                                pick_rate()});
            end
            drain();
        end

        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/poi_pkg.sv
sv/poi_mul.sv
sv/poi_cordic.sv
sv/planar_odometry_integrator.sv
sv/poi_chk.sv
sim/tb_top.sv
